/* rtl/vvh_pkg.sv */
`default_nettype none
package vvh_pkg;

    localparam int SPACE_RADIUS_MM = 1024;
    localparam int GRID_MAX        = 32;
    localparam int COUNT_WIDTH     = 16;

    // port field widths
    localparam int POS_W     = 13;
    localparam int SIZE_W    = 12;
    localparam int OUT_IDX_W = 15;
    localparam int OUT_CNT_W = 16;
    localparam int TOTAL_W   = 16;

    // input beat operations
    localparam logic FUNC_RECORD = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    localparam int INDEX_W     = $clog2(GRID_MAX);
    localparam int GRID_W      = INDEX_W + 1;
    localparam int QUOT_W      = INDEX_W + 1;
    localparam int STORE_DEPTH = GRID_MAX * GRID_MAX * GRID_MAX;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int TOT_W       = $clog2(STORE_DEPTH + 1);
    localparam int SUM_W       = POS_W + 1;
    localparam int DVD_W       = POS_W;
    localparam int DIV_SH_W    = SIZE_W + QUOT_W - 1;
    localparam int DIV_STEP_W  = $clog2(QUOT_W);
    localparam int T_W         = GRID_W + INDEX_W;
    localparam int IDXP_W      = GRID_W + T_W;
    localparam int PROD_W      = SIZE_W + INDEX_W + 1;
    localparam int CENTRE_W    = PROD_W + 1;

    localparam int SIZE_RESET     = 100;
    localparam int GRID_RESET_RAW = (2 * SPACE_RADIUS_MM + SIZE_RESET - 1) / SIZE_RESET;
    localparam int GRID_RESET     = (GRID_RESET_RAW > GRID_MAX) ? GRID_MAX :
                                    ((GRID_RESET_RAW < 1) ? 1 : GRID_RESET_RAW);

    // doubled-centre limits of the uncommon regions
    localparam logic signed [CENTRE_W-1:0] CENTRE_UP   = CENTRE_W'(1000);
    localparam logic signed [CENTRE_W-1:0] CENTRE_DOWN = CENTRE_W'(-1600);
    localparam logic signed [CENTRE_W-1:0] CENTRE_BACK = CENTRE_W'(600);
    localparam logic signed [CENTRE_W-1:0] CENTRE_SIDE = CENTRE_W'(1600);
    localparam logic signed [CENTRE_W-1:0] TWO_RADIUS  = CENTRE_W'(2 * SPACE_RADIUS_MM);

    typedef struct packed {
        logic              start;
        logic [DVD_W-1:0]  dividend;
        logic [SIZE_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [QUOT_W-1:0] quotient;
    } div_rsp_t;

    // doubled centre: -2R + (2i+1)*size
    function automatic logic signed [CENTRE_W-1:0] centre2(
        input logic [INDEX_W-1:0] idx,
        input logic [SIZE_W-1:0]  size
    );
        logic [PROD_W-1:0] prod;
        prod = PROD_W'({idx, 1'b1}) * PROD_W'(size);
        return $signed({1'b0, prod}) - TWO_RADIUS;
    endfunction

    function automatic logic [OUT_CNT_W-1:0] count_out(input logic [COUNT_WIDTH-1:0] c);
        logic [32:0] w;
        w = 33'(c);
        return (w > 33'h0FFFF) ? '1 : w[OUT_CNT_W-1:0];
    endfunction

endpackage
`default_nettype wire

/* rtl/vvh_in_if.sv */
`default_nettype none
interface vvh_in_if;
    logic                              valid;
    logic                              ready;
    logic                              func;
    logic signed [vvh_pkg::POS_W-1:0]  pos_x;
    logic signed [vvh_pkg::POS_W-1:0]  pos_y;
    logic signed [vvh_pkg::POS_W-1:0]  pos_z;

    modport source (output valid, func, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, func, pos_x, pos_y, pos_z, output ready);
endinterface
`default_nettype wire

/* rtl/vvh_out_if.sv */
`default_nettype none
interface vvh_out_if;
    logic                             valid;
    logic                             ready;
    logic [vvh_pkg::OUT_IDX_W-1:0]    voxel_index;
    logic [vvh_pkg::OUT_CNT_W-1:0]    visit_count;
    logic                             is_uncommon;
    logic                             first_uncommon;
    logic [vvh_pkg::TOTAL_W-1:0]      visited_total;
    logic [vvh_pkg::TOTAL_W-1:0]      uncommon_total;

    modport source (output valid, voxel_index, visit_count, is_uncommon, first_uncommon,
                    visited_total, uncommon_total, input ready);
    modport sink   (input valid, voxel_index, visit_count, is_uncommon, first_uncommon,
                    visited_total, uncommon_total, output ready);
endinterface
`default_nettype wire

/* rtl/vvh_div.sv */
`default_nettype none
module vvh_div (
    input  logic              clk,
    input  logic              rst_n,
    input  vvh_pkg::div_req_t req,
    output vvh_pkg::div_rsp_t rsp
);
    import vvh_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [DVD_W-1:0]      rem_reg;
    logic [DIV_SH_W-1:0]   dsr_sh_reg;
    logic [QUOT_W-1:0]     quot_reg;

    logic                  sat;
    logic                  ge;

    // quotient would not fit: saturate to all ones
    assign sat = (SIZE_W + QUOT_W)'(req.dividend) >= {req.divisor, QUOT_W'(0)};
    assign ge  = DIV_SH_W'(rem_reg) >= dsr_sh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            if (req.start)
            begin
                busy_reg <= !sat;
                done_reg <= sat;
                step_reg <= DIV_STEP_W'(QUOT_W - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    done_reg <= 1'b0;
                    step_reg <= step_reg - DIV_STEP_W'(1);
                end
            end
            else
            begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg    <= req.dividend;
            dsr_sh_reg <= {req.divisor, (QUOT_W - 1)'(0)};
            quot_reg   <= sat ? '1 : '0;
        end
        else if (busy_reg)
        begin
            // one restoring step per cycle
            if (ge)
            begin
                rem_reg <= rem_reg - dsr_sh_reg[DVD_W-1:0];
            end
            quot_reg   <= {quot_reg[QUOT_W-2:0], ge};
            dsr_sh_reg <= dsr_sh_reg >> 1;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quot_reg;

endmodule
`default_nettype wire

/* rtl/vvh_store.sv */
`default_nettype none
module vvh_store (
    input  logic                            clk,
    input  logic                            wr_en,
    input  logic [vvh_pkg::ADDR_W-1:0]      wr_addr,
    input  logic [vvh_pkg::COUNT_WIDTH-1:0] wr_data,
    input  logic                            rd_en,
    input  logic [vvh_pkg::ADDR_W-1:0]      rd_addr,
    output logic [vvh_pkg::COUNT_WIDTH-1:0] rd_data
);
    import vvh_pkg::*;

    logic [COUNT_WIDTH-1:0] mem [STORE_DEPTH];
    logic [COUNT_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

/* rtl/voxel_visit_histogram_top.sv */
// Record beat: three axis divisions through one shared restoring divider (shorter when
// the quotient saturates) plus a store read-modify-write. The next beat is taken once the
// sequencer is back in idle.
// Clear beat: one divider pass for the grid size, then a store clearing pass and a zero result.
// Reset: asynchronous, active low; a store clearing pass follows during which no
// beat is accepted (configuration writes are taken).
`default_nettype none
module voxel_visit_histogram_top (
    input  logic                       clk,
    input  logic                       rst_n,
    vvh_in_if.sink                     item,
    vvh_out_if.source                  result,
    input  logic                       cfg_we,
    input  logic [vvh_pkg::SIZE_W-1:0] cfg_wdata
);
    import vvh_pkg::*;

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_GRID    = 4'd1;
    localparam logic [3:0] ST_CLEAR   = 4'd2;
    localparam logic [3:0] ST_CLR_RSP = 4'd3;
    localparam logic [3:0] ST_LAUNCH  = 4'd4;
    localparam logic [3:0] ST_DIV     = 4'd5;
    localparam logic [3:0] ST_MAP     = 4'd6;
    localparam logic [3:0] ST_ADDR    = 4'd7;
    localparam logic [3:0] ST_READ    = 4'd8;
    localparam logic [3:0] ST_UPD     = 4'd9;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    logic [3:0]             state_reg, state_next;
    logic [SIZE_W-1:0]      cfg_size_reg;
    logic [SIZE_W-1:0]      active_size_reg;
    logic [GRID_W-1:0]      grid_reg;
    logic [TOT_W-1:0]       visited_reg;
    logic [TOT_W-1:0]       uncommon_reg;
    logic [ADDR_W-1:0]      clr_addr_reg;
    logic                   clr_rsp_reg;
    logic [1:0]             axis_reg;
    logic                   res_valid_reg;

    logic [POS_W-1:0]       pos_x_reg, pos_y_reg, pos_z_reg;
    logic [INDEX_W-1:0]     ix_reg, iy_reg, iz_reg;
    logic [T_W-1:0]         t_reg;
    logic signed [CENTRE_W-1:0] cx_reg, cy_reg, cz_reg;
    logic [ADDR_W-1:0]      idx_reg;
    logic                   unc_reg;
    logic [OUT_IDX_W-1:0]   res_idx_reg;
    logic [OUT_CNT_W-1:0]   res_cnt_reg;
    logic                   res_unc_reg;
    logic                   res_first_reg;
    logic [TOTAL_W-1:0]     res_visited_reg;
    logic [TOTAL_W-1:0]     res_uncommon_reg;

    logic                   item_acc;
    logic                   out_free;
    logic [SIZE_W-1:0]      cfg_nz;
    logic [POS_W-1:0]       coord;
    logic [SUM_W-1:0]       coord_sum;
    logic [DVD_W-1:0]       axis_dividend;
    logic [GRID_W-1:0]      grid_calc;
    logic [GRID_W-1:0]      grid_m1;
    logic [INDEX_W-1:0]     q_clamp;
    logic signed [CENTRE_W-1:0] ax;
    logic                   unc_calc;
    logic [COUNT_WIDTH-1:0] cnt;
    logic [COUNT_WIDTH-1:0] cnt_new;
    logic                   cnt_sat;
    logic                   first_visit;
    logic [TOT_W-1:0]       visited_new;
    logic [TOT_W-1:0]       uncommon_new;

    div_req_t               div_req;
    div_rsp_t               div_rsp;

    logic                   st_wr_en;
    logic [ADDR_W-1:0]      st_wr_addr;
    logic [COUNT_WIDTH-1:0] st_wr_data;
    logic                   st_rd_en;

    assign item.ready = (state_reg == ST_IDLE);
    assign item_acc   = item.valid && item.ready;
    assign out_free   = !res_valid_reg || result.ready;
    assign cfg_nz     = (cfg_size_reg == '0) ? SIZE_W'(1) : cfg_size_reg;

    always_comb
    begin
        case (axis_reg)
            AXIS_X:  coord = pos_x_reg;
            AXIS_Y:  coord = pos_y_reg;
            default: coord = pos_z_reg;
        endcase
    end

    // shift to the grid origin; negative sums land in voxel zero
    assign coord_sum     = {coord[POS_W-1], coord} + SUM_W'(SPACE_RADIUS_MM);
    assign axis_dividend = coord_sum[SUM_W-1] ? '0 : coord_sum[POS_W-1:0];

    always_comb
    begin
        div_req.start    = (item_acc && (item.func == FUNC_CLEAR)) || (state_reg == ST_LAUNCH);
        div_req.dividend = (state_reg == ST_IDLE) ? DVD_W'(2 * SPACE_RADIUS_MM - 1)
                                                  : axis_dividend;
        div_req.divisor  = (state_reg == ST_IDLE) ? cfg_nz : active_size_reg;
    end

    vvh_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ceil(2R/size) = floor((2R-1)/size) + 1, capped at the grid limit
    assign grid_calc = (div_rsp.quotient >= QUOT_W'(GRID_MAX - 1)) ? GRID_W'(GRID_MAX)
                     : GRID_W'(div_rsp.quotient) + GRID_W'(1);
    assign grid_m1   = grid_reg - GRID_W'(1);
    assign q_clamp   = (GRID_W'(div_rsp.quotient) > grid_m1) ? grid_m1[INDEX_W-1:0]
                     : div_rsp.quotient[INDEX_W-1:0];

    assign ax       = (cx_reg < 0) ? -cx_reg : cx_reg;
    assign unc_calc = (cy_reg > CENTRE_UP) || (cy_reg < CENTRE_DOWN) ||
                      (cz_reg > CENTRE_BACK) || ((ax > CENTRE_SIDE) && (cy_reg > 0));

    assign cnt_sat      = (cnt == '1);
    assign cnt_new      = cnt_sat ? cnt : cnt + COUNT_WIDTH'(1);
    assign first_visit  = (cnt == '0);
    assign visited_new  = visited_reg + TOT_W'(first_visit);
    assign uncommon_new = uncommon_reg + TOT_W'(first_visit && unc_reg);

    always_comb
    begin
        st_wr_en   = (state_reg == ST_CLEAR) || ((state_reg == ST_UPD) && out_free && !cnt_sat);
        st_wr_addr = (state_reg == ST_CLEAR) ? clr_addr_reg : idx_reg;
        st_wr_data = (state_reg == ST_CLEAR) ? '0 : cnt_new;
        st_rd_en   = (state_reg == ST_READ);
    end

    vvh_store u_store (
        .clk     (clk),
        .wr_en   (st_wr_en),
        .wr_addr (st_wr_addr),
        .wr_data (st_wr_data),
        .rd_en   (st_rd_en),
        .rd_addr (idx_reg),
        .rd_data (cnt)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_acc)
                begin
                    state_next = (item.func == FUNC_CLEAR) ? ST_GRID : ST_LAUNCH;
                end
            end
            ST_GRID:
            begin
                if (div_rsp.done)
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                if (clr_addr_reg == '1)
                begin
                    state_next = clr_rsp_reg ? ST_CLR_RSP : ST_IDLE;
                end
            end
            ST_CLR_RSP:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LAUNCH: state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = (axis_reg == AXIS_Z) ? ST_MAP : ST_LAUNCH;
                end
            end
            ST_MAP:  state_next = ST_ADDR;
            ST_ADDR: state_next = ST_READ;
            ST_READ: state_next = ST_UPD;
            ST_UPD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            cfg_size_reg    <= SIZE_W'(SIZE_RESET);
            active_size_reg <= SIZE_W'(SIZE_RESET);
            grid_reg        <= GRID_W'(GRID_RESET);
            visited_reg     <= '0;
            uncommon_reg    <= '0;
            clr_addr_reg    <= '0;
            clr_rsp_reg     <= 1'b0;
            axis_reg        <= AXIS_X;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                cfg_size_reg <= cfg_wdata;
            end
            if (((state_reg == ST_UPD) || (state_reg == ST_CLR_RSP)) && out_free)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    axis_reg <= AXIS_X;
                    if (item_acc && (item.func == FUNC_CLEAR))
                    begin
                        active_size_reg <= cfg_nz;
                        visited_reg     <= '0;
                        uncommon_reg    <= '0;
                        clr_addr_reg    <= '0;
                        clr_rsp_reg     <= 1'b1;
                    end
                end
                ST_GRID:
                begin
                    if (div_rsp.done)
                    begin
                        grid_reg <= grid_calc;
                    end
                end
                ST_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                end
                ST_DIV:
                begin
                    if (div_rsp.done)
                    begin
                        axis_reg <= axis_reg + 2'd1;
                    end
                end
                ST_UPD:
                begin
                    if (out_free)
                    begin
                        visited_reg  <= visited_new;
                        uncommon_reg <= uncommon_new;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            pos_x_reg <= item.pos_x;
            pos_y_reg <= item.pos_y;
            pos_z_reg <= item.pos_z;
        end
        if ((state_reg == ST_DIV) && div_rsp.done)
        begin
            case (axis_reg)
                AXIS_X:  ix_reg <= q_clamp;
                AXIS_Y:  iy_reg <= q_clamp;
                default: iz_reg <= q_clamp;
            endcase
        end
        if (state_reg == ST_MAP)
        begin
            t_reg  <= T_W'(iy_reg) + T_W'(grid_reg) * T_W'(iz_reg);
            cx_reg <= centre2(ix_reg, active_size_reg);
            cy_reg <= centre2(iy_reg, active_size_reg);
            cz_reg <= centre2(iz_reg, active_size_reg);
        end
        if (state_reg == ST_ADDR)
        begin
            idx_reg <= ADDR_W'(IDXP_W'(ix_reg) + IDXP_W'(grid_reg) * IDXP_W'(t_reg));
            unc_reg <= unc_calc;
        end
        if ((state_reg == ST_UPD) && out_free)
        begin
            res_idx_reg      <= OUT_IDX_W'(idx_reg);
            res_cnt_reg      <= count_out(cnt_new);
            res_unc_reg      <= unc_reg;
            res_first_reg    <= first_visit && unc_reg;
            res_visited_reg  <= TOTAL_W'(visited_new);
            res_uncommon_reg <= TOTAL_W'(uncommon_new);
        end
        else if ((state_reg == ST_CLR_RSP) && out_free)
        begin
            res_idx_reg      <= '0;
            res_cnt_reg      <= '0;
            res_unc_reg      <= 1'b0;
            res_first_reg    <= 1'b0;
            res_visited_reg  <= '0;
            res_uncommon_reg <= '0;
        end
    end

    assign result.valid          = res_valid_reg;
    assign result.voxel_index    = res_idx_reg;
    assign result.visit_count    = res_cnt_reg;
    assign result.is_uncommon    = res_unc_reg;
    assign result.first_uncommon = res_first_reg;
    assign result.visited_total  = res_visited_reg;
    assign result.uncommon_total = res_uncommon_reg;

`ifndef ASSERT_OFF
    a_first_is_uncommon: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.first_uncommon) |->
        (result.is_uncommon && (result.visit_count == OUT_CNT_W'(1))))
        else $error("first uncommon beat without uncommon voxel at count one");

    a_totals_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        uncommon_reg <= visited_reg)
        else $error("uncommon total exceeds visited total");

    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> ((state_reg == ST_GRID) || (state_reg == ST_DIV)))
        else $error("divider finished outside a wait state");
`endif

endmodule
`default_nettype wire
